### rtl/hsv2rgb_pkg.sv
// ----------------------------------------------------------------------------
// HSV to RGB package
// Shared types and fixed-point constants for the HSV to RGB pipeline.
// ----------------------------------------------------------------------------
package hsv2rgb_pkg;

  // 1/15 reciprocal, 14 fractional bits (hue[14:6] / 15)
  localparam logic [19:0] RecipFifteen = 20'd1093;
  // 1/6 reciprocal, 6 fractional bits (sector count / 6)
  localparam logic [9:0]  RecipSix     = 10'd11;
  localparam logic [9:0]  SixTimes     = 10'd6;
  localparam logic [9:0]  FifteenTimes = 10'd15;
  // 60 degrees in 1/16 degree units
  localparam logic [9:0]  SectorSpan   = 10'd960;
  // round(P/255) == ((P + 127) * 32897) >> 23
  localparam logic [15:0] ChromaBias   = 16'd127;
  localparam logic [30:0] RecipChroma  = 31'd32897;
  // round(P*ramp/244800) == (((P*ramp + 122400) >> 6) * 1122868) >> 32
  localparam logic [25:0] SecHalfDen   = 26'd122400;
  localparam logic [40:0] RecipSec     = 41'd1122868;

  typedef enum logic [2:0] {
    SEC_RED_YEL = 3'd0,
    SEC_YEL_GRN = 3'd1,
    SEC_GRN_CYN = 3'd2,
    SEC_CYN_BLU = 3'd3,
    SEC_BLU_MAG = 3'd4,
    SEC_MAG_RED = 3'd5
  } sector_e;

  typedef struct packed {
    logic       neg;
    sector_e    sector;
    logic [9:0] ramp;
  } hue_info_t;

  typedef struct packed {
    hue_info_t  hue;
    logic [7:0] chroma;
    logic [7:0] minimum;
    logic [7:0] second;
  } mix_t;

endpackage

### rtl/hsv2rgb_hue.sv
// ----------------------------------------------------------------------------
// HSV to RGB hue splitter
// Two stages: hue to 60-degree sector and ramp position within the sector.
// ----------------------------------------------------------------------------
module hsv2rgb_hue
  import hsv2rgb_pkg::*;
(
  input  logic        clk_i,
  input  logic [15:0] hue_i,
  output hue_info_t   hue_o
);

  logic [19:0] qmul;
  logic [5:0]  q_q;
  logic [8:0]  h6_q;
  logic [5:0]  lo_q;
  logic        neg_q;

  logic [9:0]  q11;
  logic [2:0]  q6;
  logic [9:0]  sec_w;
  logic [9:0]  r15_w;
  logic [9:0]  rem;
  hue_info_t   hue_d, hue_q;

  // stage 1: 60-degree count (hue >> 6) / 15
  assign qmul = 20'(hue_i[14:6]) * RecipFifteen;

  always_ff @(posedge clk_i) begin
    q_q   <= qmul[19:14];
    h6_q  <= hue_i[14:6];
    lo_q  <= hue_i[5:0];
    neg_q <= hue_i[15];
  end

  // stage 2: sector = count mod 6, remainder within sector
  assign q11   = 10'(q_q) * RecipSix;
  assign q6    = q11[8:6];
  assign sec_w = 10'(q_q) - 10'(q6) * SixTimes;
  assign r15_w = 10'(h6_q) - 10'(q_q) * FifteenTimes;
  assign rem   = {r15_w[3:0], lo_q};

  always_comb begin
    hue_d.neg    = neg_q;
    hue_d.sector = sector_e'(sec_w[2:0]);
    hue_d.ramp   = sec_w[0] ? (SectorSpan - rem) : rem;
  end

  always_ff @(posedge clk_i) begin
    hue_q <= hue_d;
  end

  assign hue_o = hue_q;

endmodule

### rtl/hsv2rgb_chroma.sv
// ----------------------------------------------------------------------------
// HSV to RGB chroma path
// Four stages: chroma, minimum and secondary component from S, V and ramp.
// ----------------------------------------------------------------------------
module hsv2rgb_chroma
  import hsv2rgb_pkg::*;
(
  input  logic       clk_i,
  input  logic [7:0] saturation_i,
  input  logic [7:0] brightness_i,
  input  hue_info_t  hue_i,
  output mix_t       mix_o
);

  logic [15:0] prod_q1, prod_q2;
  logic [7:0]  val_q1, val_q2;
  logic [15:0] cnum;
  logic [30:0] cprod_q;
  logic [25:0] xnum;
  logic [19:0] xdiv_q;
  logic [7:0]  chroma;
  logic [7:0]  c_q3, m_q3, c_q4, m_q4;
  hue_info_t   hue_q3, hue_q4;
  logic [40:0] xprod_q;

  // stage 1: P = V * S
  always_ff @(posedge clk_i) begin
    prod_q1 <= 16'(brightness_i) * 16'(saturation_i);
    val_q1  <= brightness_i;
  end

  // stage 2: rounded P / 255 as reciprocal product
  assign cnum = prod_q1 + ChromaBias;

  always_ff @(posedge clk_i) begin
    cprod_q <= 31'(cnum) * RecipChroma;
    prod_q2 <= prod_q1;
    val_q2  <= val_q1;
  end

  // stage 3: P * ramp, chroma and minimum
  assign xnum   = 26'(prod_q2) * 26'(hue_i.ramp) + SecHalfDen;
  assign chroma = cprod_q[30:23];

  always_ff @(posedge clk_i) begin
    xdiv_q <= xnum[25:6];
    c_q3   <= chroma;
    m_q3   <= val_q2 - chroma;
    hue_q3 <= hue_i;
  end

  // stage 4: divide by 3825 as reciprocal product
  always_ff @(posedge clk_i) begin
    xprod_q <= 41'(xdiv_q) * RecipSec;
    c_q4    <= c_q3;
    m_q4    <= m_q3;
    hue_q4  <= hue_q3;
  end

  always_comb begin
    mix_o.hue     = hue_q4;
    mix_o.chroma  = c_q4;
    mix_o.minimum = m_q4;
    mix_o.second  = xprod_q[39:32];
  end

endmodule

### rtl/hsv2rgb_mix.sv
// ----------------------------------------------------------------------------
// HSV to RGB output mixer
// Places chroma and secondary by sector (neither for a negative hue), adds the minimum, registers RGB.
// ----------------------------------------------------------------------------
module hsv2rgb_mix
  import hsv2rgb_pkg::*;
(
  input  logic       clk_i,
  input  mix_t       mix_i,
  output logic [7:0] red_o,
  output logic [7:0] green_o,
  output logic [7:0] blue_o
);

  logic [7:0] r_w, g_w, b_w;
  logic [7:0] red_q, green_q, blue_q;

  always_comb begin
    r_w = '0;
    g_w = '0;
    b_w = '0;
    if (!mix_i.hue.neg) begin
      case (mix_i.hue.sector)
        SEC_RED_YEL: begin r_w = mix_i.chroma; g_w = mix_i.second; end
        SEC_YEL_GRN: begin r_w = mix_i.second; g_w = mix_i.chroma; end
        SEC_GRN_CYN: begin g_w = mix_i.chroma; b_w = mix_i.second; end
        SEC_CYN_BLU: begin g_w = mix_i.second; b_w = mix_i.chroma; end
        SEC_BLU_MAG: begin r_w = mix_i.second; b_w = mix_i.chroma; end
        default: begin r_w = mix_i.chroma; b_w = mix_i.second; end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    red_q   <= r_w + mix_i.minimum;
    green_q <= g_w + mix_i.minimum;
    blue_q  <= b_w + mix_i.minimum;
  end

  assign red_o   = red_q;
  assign green_o = green_q;
  assign blue_o  = blue_q;

endmodule

### rtl/hsv_to_rgb_converter.sv
// ----------------------------------------------------------------------------
// HSV to RGB converter
// Throughput: one pixel per cycle; busy_o is never asserted.
// The five register stages (product, chroma, ramp product, divide, mix) carry each start transfer to valid_o.
// Reset clears the valid pipeline only; results cannot be held off.
// ----------------------------------------------------------------------------
module hsv_to_rgb_converter
  import hsv2rgb_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic [15:0] hue_i,
  input  logic [7:0]  saturation_i,
  input  logic [7:0]  brightness_i,
  output logic        valid_o,
  output logic [7:0]  red_o,
  output logic [7:0]  green_o,
  output logic [7:0]  blue_o
);

  logic [4:0] vld_d, vld_q;
  hue_info_t  hue_info;
  mix_t       mix;

  assign busy_o = 1'b0;
  assign vld_d  = {vld_q[3:0], start_i & ~busy_o};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  assign valid_o = vld_q[4];

  hsv2rgb_hue u_hue (
    .clk_i  (clk_i),
    .hue_i  (hue_i),
    .hue_o  (hue_info)
  );

  hsv2rgb_chroma u_chroma (
    .clk_i        (clk_i),
    .saturation_i (saturation_i),
    .brightness_i (brightness_i),
    .hue_i        (hue_info),
    .mix_o        (mix)
  );

  hsv2rgb_mix u_mix (
    .clk_i   (clk_i),
    .mix_i   (mix),
    .red_o   (red_o),
    .green_o (green_o),
    .blue_o  (blue_o)
  );

  a_lat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o |-> ##5 valid_o)
    else $error("transfer did not produce a result after 5 cycles");

  a_gray: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o && hue_i[15] |-> ##5 (red_o == green_o && green_o == blue_o))
    else $error("negative hue did not give gray");

  a_nosat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o && saturation_i == 8'd0 |-> ##5
      (red_o == $past(brightness_i, 5) && green_o == $past(brightness_i, 5) &&
       blue_o == $past(brightness_i, 5)))
    else $error("zero saturation did not give brightness");

endmodule
